[src/isfd_pkg.sv]
// Shared types, constants and frame codes for the IMU serial frame decoder.
// No dependencies; every other file imports this package.

package isfd_pkg;

  // Frame geometry
  localparam int FRAME_BYTES = 11;
  localparam int STORE_DEPTH = 10;
  localparam int POS_W       = $clog2(FRAME_BYTES);
  localparam int STORE_IDX_W = $clog2(STORE_DEPTH);

  // Result field widths
  localparam int AXIS_W  = 28;
  localparam int TEMP_W  = 25;
  localparam int RAW_W   = 16;
  localparam int SCALE_W = 13;

  // Header and type bytes
  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACCEL  = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  // Q16 scale per kind: 16/32768, 2000/32768, 180/32768 times 65536
  localparam logic [SCALE_W-1:0] SCALE_ACCEL = 13'd32;
  localparam logic [SCALE_W-1:0] SCALE_GYRO  = 13'd4000;
  localparam logic [SCALE_W-1:0] SCALE_ANGLE = 13'd360;

  // Temperature: floor(raw*65536/340) + 36.25 in Q16, split as
  // 192*raw + floor((64*(raw+32768)+53)/85) + TEMP_OFFSET.
  // TEMP_RECIP = ceil(2^31/85), exact for numerators below 2^22.
  localparam logic [24:0] TEMP_RECIP     = 25'd25264514;
  localparam int          TEMP_RECIP_SH  = 31;
  localparam logic [21:0] TEMP_BIAS      = 22'd53;
  localparam logic [23:0] TEMP_RAW_SCALE = 24'd192;
  localparam logic [25:0] TEMP_OFFSET    = 26'd2351007;

  typedef enum logic [1:0] {
    KIND_ACCEL = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_t;

  typedef logic [STORE_DEPTH-1:0][7:0] frame_bytes_t;

  typedef struct packed {
    kind_t                     kind;
    logic signed [AXIS_W-1:0]  axis_x;
    logic signed [AXIS_W-1:0]  axis_y;
    logic signed [AXIS_W-1:0]  axis_z;
    logic signed [TEMP_W-1:0]  temperature;
  } result_t;

  // Capture status handed to the output stage
  typedef struct packed {
    logic frame_end;  // beat carries the last byte of a frame
    logic frame_ok;   // header and type of that frame are valid
  } cap_status_t;

endpackage

[src/isfd_channels.sv]
// Handshake channels of the IMU serial frame decoder: byte input and result output.
// Depends on isfd_pkg.

interface isfd_in_if
  import isfd_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface isfd_out_if
  import isfd_pkg::*;
();
  logic                     valid;
  logic                     ready;
  kind_t                    kind;
  logic signed [AXIS_W-1:0] axis_x;
  logic signed [AXIS_W-1:0] axis_y;
  logic signed [AXIS_W-1:0] axis_z;
  logic signed [TEMP_W-1:0] temperature;

  modport source (output valid, output kind, output axis_x, output axis_y,
                  output axis_z, output temperature, input ready);
  modport sink   (input valid, input kind, input axis_x, input axis_y,
                  input axis_z, input temperature, output ready);
endinterface

[src/isfd_capture.sv]
// Byte position counter and frame byte store (bytes 0..9 of the current frame).
// Depends on isfd_pkg.

module isfd_capture
  import isfd_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         beat,
  input  logic [7:0]   rx_byte,
  output frame_bytes_t frame_bytes,
  output logic         frame_end
);

  logic [POS_W-1:0] pos_r, pos_nxt;
  frame_bytes_t     store_r;

  assign frame_end = (pos_r == POS_W'(FRAME_BYTES - 1));

  // Position wraps after the last byte; no resync
  always_comb begin
    pos_nxt = pos_r;
    if (beat) begin
      pos_nxt = frame_end ? '0 : pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= '0;
    end else begin
      pos_r <= pos_nxt;
    end
  end

  // Store bytes 0..9; checksum and later bytes are only counted
  always_ff @(posedge clk) begin
    for (int i = 0; i < STORE_DEPTH; i++) begin
      if (beat && (pos_r == POS_W'(i))) begin
        store_r[i] <= rx_byte;
      end
    end
  end

  assign frame_bytes = store_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    pos_r <= POS_W'(FRAME_BYTES - 1))
    else $error("byte position past end of frame");

  a_wrap: assert property (@(posedge clk) disable iff (!rst_n)
    (beat && frame_end) |=> (pos_r == '0))
    else $error("position did not wrap after last byte");

endmodule

[src/isfd_convert.sv]
// Frame check and Q16 conversion of axes and temperature from stored frame bytes.
// Depends on isfd_pkg.

module isfd_convert
  import isfd_pkg::*;
(
  input  frame_bytes_t frame_bytes,
  output logic         frame_ok,
  output result_t      result
);

  logic [SCALE_W-1:0]             scale;
  kind_t                          kind;
  logic                           type_ok;
  logic signed [SCALE_W:0]        scale_s;
  logic signed [RAW_W-1:0]        raw_x, raw_y, raw_z, raw_t;
  logic signed [RAW_W+SCALE_W:0]  prod_x, prod_y, prod_z;
  logic [RAW_W-1:0]               u_t;
  logic [21:0]                    t_num;
  logic [46:0]                    recip_prod;
  logic [RAW_W-1:0]               t_quo;
  logic signed [23:0]             t_base;
  logic signed [25:0]             t_sum;

  // Type byte decode
  always_comb begin
    type_ok = 1'b1;
    kind    = KIND_ACCEL;
    scale   = SCALE_ACCEL;
    case (frame_bytes[1])
      TYPE_ACCEL: begin
        kind  = KIND_ACCEL;
        scale = SCALE_ACCEL;
      end
      TYPE_GYRO: begin
        kind  = KIND_GYRO;
        scale = SCALE_GYRO;
      end
      TYPE_ANGLE: begin
        kind  = KIND_ANGLE;
        scale = SCALE_ANGLE;
      end
      default: begin
        type_ok = 1'b0;
      end
    endcase
  end

  assign frame_ok = (frame_bytes[0] == HEADER_BYTE) && type_ok;

  // Little-endian raw values
  assign raw_x = $signed({frame_bytes[3], frame_bytes[2]});
  assign raw_y = $signed({frame_bytes[5], frame_bytes[4]});
  assign raw_z = $signed({frame_bytes[7], frame_bytes[6]});
  assign raw_t = $signed({frame_bytes[9], frame_bytes[8]});

  // Axes: one constant-range multiply each
  assign scale_s = $signed({1'b0, scale});
  assign prod_x  = raw_x * scale_s;
  assign prod_y  = raw_y * scale_s;
  assign prod_z  = raw_z * scale_s;

  // Temperature: floor division by 85 on an offset-binary numerator
  assign u_t        = {~raw_t[RAW_W-1], raw_t[RAW_W-2:0]};
  assign t_num      = {u_t, 6'b0} + TEMP_BIAS;
  assign recip_prod = t_num * TEMP_RECIP;
  assign t_quo      = recip_prod[46:TEMP_RECIP_SH];
  assign t_base     = raw_t * $signed(TEMP_RAW_SCALE);
  assign t_sum      = 26'(t_base) + $signed({10'b0, t_quo}) + $signed(TEMP_OFFSET);

  always_comb begin
    result.kind        = kind;
    result.axis_x      = prod_x[AXIS_W-1:0];
    result.axis_y      = prod_y[AXIS_W-1:0];
    result.axis_z      = prod_z[AXIS_W-1:0];
    result.temperature = t_sum[TEMP_W-1:0];
  end

endmodule

[src/imu_serial_frame_decoder.sv]
// Top level of the IMU serial frame decoder: byte capture, conversion, result register.
// Depends on isfd_pkg, isfd_channels, isfd_capture and isfd_convert.

// Takes one serial byte per beat and groups bytes into 11-byte frames purely by
// count from reset, with no resynchronization. The beat that carries the last
// byte of a frame is checked (header 0x55, type 0x51/0x52/0x53); a good frame
// loads one result into the output register on that clock edge, so the result
// is visible the cycle after its last byte. Bad frames give no result and the
// checksum byte is not examined. A byte is accepted every cycle while the output
// register is empty or being drained; the one output register is the only
// stage, so throughput is one byte per cycle under that condition.

module imu_serial_frame_decoder
  import isfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  isfd_in_if.sink    in_chan,
  isfd_out_if.source out_chan
);

  logic         beat;
  logic         load;
  frame_bytes_t frame_bytes;
  cap_status_t  cap_status;
  result_t      result;
  logic         out_valid_r, out_valid_nxt;
  result_t      out_data_r;

  assign in_chan.ready = !out_valid_r || out_chan.ready;
  assign beat          = in_chan.valid && in_chan.ready;

  isfd_capture u_capture (
    .clk         (clk),
    .rst_n       (rst_n),
    .beat        (beat),
    .rx_byte     (in_chan.rx_byte),
    .frame_bytes (frame_bytes),
    .frame_end   (cap_status.frame_end)
  );

  isfd_convert u_convert (
    .frame_bytes (frame_bytes),
    .frame_ok    (cap_status.frame_ok),
    .result      (result)
  );

  assign load = beat && cap_status.frame_end && cap_status.frame_ok;

  // Output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) begin
      out_valid_nxt = 1'b1;
    end else if (out_chan.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (load) begin
      out_data_r <= result;
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.kind        = out_data_r.kind;
  assign out_chan.axis_x      = out_data_r.axis_x;
  assign out_chan.axis_y      = out_data_r.axis_y;
  assign out_chan.axis_z      = out_data_r.axis_z;
  assign out_chan.temperature = out_data_r.temperature;

  a_result_from_frame: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(beat && cap_status.frame_end && cap_status.frame_ok))
    else $error("result appeared without a good frame end");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_chan.ready && !load) |=> !out_valid_r)
    else $error("taken result was not cleared");

endmodule

[dv/tb.sv]
// Self-checking testbench for imu_serial_frame_decoder: frames, rejects, random traffic, stalls.
// Depends on isfd_pkg, isfd_channels and the decoder RTL under src/.

module tb;
  import isfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Q16 conversion constants
  localparam longint ACCEL_Q16       = 32;
  localparam longint GYRO_Q16        = 4000;
  localparam longint ANGLE_Q16       = 360;
  localparam longint TEMP_OFFSET_Q16 = 2375680;
  localparam int     RANDOM_BYTES    = 1375;

  logic clk = 1'b0;
  logic rst_n;

  isfd_in_if  in_if ();
  isfd_out_if out_if ();

  imu_serial_frame_decoder u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Frame tracker state and expected results
  logic [7:0]  frame_buf [STORE_DEPTH];
  int unsigned rx_pos;
  result_t     pending_results[$];
  int          mismatch_count;
  int          bytes_sent;
  bit          no_idle;
  int          hold_cycles;

  // Little-endian signed word from the frame buffer
  function automatic logic signed [15:0] raw_word(int lo);
    return {frame_buf[lo+1], frame_buf[lo]};
  endfunction

  function automatic logic [AXIS_W-1:0] q16_axis(int lo, longint scale);
    longint v;
    v = longint'(raw_word(lo)) * scale;
    return v[AXIS_W-1:0];
  endfunction

  // floor(raw * 65536 / 340) + 36.25 degrees, Q16
  function automatic logic [TEMP_W-1:0] celsius_q16(logic signed [15:0] raw);
    longint p;
    longint q;
    p = longint'(raw) * 65536;
    if (p >= 0) q = p / 340;
    else q = -((-p + 339) / 340);
    q = q + TEMP_OFFSET_Q16;
    return q[TEMP_W-1:0];
  endfunction

  // Advance the frame position on an accepted byte; queue a result on a good frame
  task automatic track_byte(input logic [7:0] b);
    result_t r;
    longint  scale;
    bit      good;
    if (rx_pos < STORE_DEPTH) frame_buf[rx_pos] = b;
    if (rx_pos + 1 < FRAME_BYTES) begin
      rx_pos++;
      return;
    end
    rx_pos = 0;
    good = (frame_buf[0] == HEADER_BYTE);
    scale = 0;
    r = '0;
    case (frame_buf[1])
      TYPE_ACCEL: begin
        r.kind = KIND_ACCEL;
        scale = ACCEL_Q16;
      end
      TYPE_GYRO: begin
        r.kind = KIND_GYRO;
        scale = GYRO_Q16;
      end
      TYPE_ANGLE: begin
        r.kind = KIND_ANGLE;
        scale = ANGLE_Q16;
      end
      default: good = 1'b0;
    endcase
    if (!good) return;
    r.axis_x = q16_axis(2, scale);
    r.axis_y = q16_axis(4, scale);
    r.axis_z = q16_axis(6, scale);
    r.temperature = celsius_q16(raw_word(8));
    pending_results.push_back(r);
  endtask

  // Send one byte beat; called and returns at a falling edge
  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    track_byte(b);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame(input logic [7:0] hdr, input logic [7:0] typ,
                            input logic [15:0] x, input logic [15:0] y,
                            input logic [15:0] z, input logic [15:0] t,
                            input logic [7:0] chk);
    send_byte(hdr);
    send_byte(typ);
    send_byte(x[7:0]);
    send_byte(x[15:8]);
    send_byte(y[7:0]);
    send_byte(y[15:8]);
    send_byte(z[7:0]);
    send_byte(z[15:8]);
    send_byte(t[7:0]);
    send_byte(t[15:8]);
    send_byte(chk);
  endtask

  // Fill out the current frame with junk so the next byte lands at position 0
  task automatic realign();
    while (rx_pos != 0) send_byte(8'($urandom_range(0, 255)));
  endtask

  function automatic logic [7:0] type_of_kind(int k);
    case (k)
      0: return TYPE_ACCEL;
      1: return TYPE_GYRO;
      default: return TYPE_ANGLE;
    endcase
  endfunction

  task automatic send_good_frame();
    send_frame(HEADER_BYTE, type_of_kind($urandom_range(0, 2)),
               16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
               8'($urandom));
  endtask

  // Every kind once, with full-scale positive, negative, zero and -1 raw values among them
  task automatic test_kinds_extremes();
    send_frame(HEADER_BYTE, TYPE_ACCEL, 16'h7FFF, 16'h8000, 16'h0000, 16'h7FFF, 8'h00);
    send_frame(HEADER_BYTE, TYPE_GYRO,  16'h8000, 16'h7FFF, 16'hFFFF, 16'h8000, 8'hFF);
    send_frame(HEADER_BYTE, TYPE_ANGLE, 16'h0001, 16'hFFFF, 16'h7FFF, 16'hFFFF, 8'h5A);
  endtask

  // Wrong header, and a good header with an unknown type
  task automatic test_rejected_frames();
    send_frame(8'h00, TYPE_ACCEL, 16'h1234, 16'h5678, 16'h9ABC, 16'hDEF0, 8'h11);
    send_frame(HEADER_BYTE, 8'h54, 16'hFFFF, 16'h0000, 16'h8001, 16'h0001, 8'hEE);
  endtask

  // Back-to-back beats on both sides
  task automatic test_back_to_back();
    no_idle = 1'b1;
    repeat (12) send_good_frame();
    no_idle = 0;
  endtask

  // Long receiver hold-off while frames keep arriving, so the input stalls
  task automatic test_output_backpressure();
    hold_cycles = 250;
    repeat (8) send_good_frame();
  endtask

  // Mostly good frames with random payload, some bad frames and misaligning noise
  task automatic test_random_traffic();
    int pick;
    int target;
    target = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < target) begin
      pick = $urandom_range(0, 99);
      if (pick < 75) begin
        realign();
        send_good_frame();
      end else if (pick < 85) begin
        realign();
        send_frame(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom),
                   16'($urandom), 16'($urandom), 8'($urandom));
      end else if (pick < 92) begin
        realign();
        send_frame(HEADER_BYTE, 8'($urandom_range(8'h50, 8'h54)), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom), 8'($urandom));
      end else begin
        repeat ($urandom_range(1, 12)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Result receiver: random stalls, plus an occasional long hold
  initial begin : result_sink
    int low;
    out_if.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      low = no_idle ? 0 : $urandom_range(0, 3);
      if (hold_cycles > 0) begin
        low = low + hold_cycles;
        hold_cycles = 0;
      end
      if (low > 0) begin
        out_if.ready <= 1'b0;
        repeat (low) @(negedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (!(out_if.valid === 1'b1 && out_if.ready === 1'b1));
      @(negedge clk);
    end
  end

  task automatic check_field(input string name, input logic [AXIS_W-1:0] want,
                             input logic [AXIS_W-1:0] got);
    if (got !== want) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("%0t: %s mismatch: expected %h, got %h", $realtime, name, want, got);
    end
  endtask

  // Compare each result beat with the oldest expected frame
  always @(posedge clk) begin : result_check
    result_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t: result beat with no frame pending", $realtime);
      end else begin
        want = pending_results.pop_front();
        check_field("kind", AXIS_W'(want.kind), AXIS_W'(out_if.kind));
        check_field("axis_x", want.axis_x, out_if.axis_x);
        check_field("axis_y", want.axis_y, out_if.axis_y);
        check_field("axis_z", want.axis_z, out_if.axis_z);
        check_field("temperature", AXIS_W'(want.temperature), AXIS_W'(out_if.temperature));
      end
    end
  end

  // Main sequence
  initial begin : main_seq
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'h00;
    rx_pos = 0;
    mismatch_count = 0;
    bytes_sent = 0;
    no_idle = 1'b0;
    hold_cycles = 0;
    for (int i = 0; i < STORE_DEPTH; i++) frame_buf[i] = 8'h00;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_kinds_extremes();
    test_rejected_frames();
    test_back_to_back();
    test_output_backpressure();
    test_random_traffic();

    in_if.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // Run limit
  initial begin : run_limit
    #5_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

[sim.f]
src/isfd_pkg.sv
src/isfd_channels.sv
src/isfd_capture.sv
src/isfd_convert.sv
src/imu_serial_frame_decoder.sv
dv/tb.sv
